// File: rtl/h264_access_unit_splitter_defines.svh
// Assertion macros for the access unit splitter
`ifndef H264_ACCESS_UNIT_SPLITTER_DEFINES_SVH
`define H264_ACCESS_UNIT_SPLITTER_DEFINES_SVH
`ifndef SYNTH
// Check an implication on every clock edge outside reset
`define AUS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition holds on every clock edge outside reset
`define AUS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`else
`define AUS_ASSERT(lbl, prop, msg)
`define AUS_ASSERT_ALWAYS(lbl, cond, msg)
`endif
`endif

// File: rtl/aus_pkg.sv
// Shared types and constants for the access unit splitter
package aus_pkg;

	localparam int MAX_FRAME_LIMIT  = 1048576;
	localparam int LOOKAHEAD_BYTES  = 8;
	localparam int WIN_LEN          = LOOKAHEAD_BYTES + 1;
	localparam int MIN_FRAME_BYTES  = 16;
	localparam int LEN_W            = 21;
	localparam int OFS_W            = 48;
	localparam int FILL_W           = $clog2(WIN_LEN + 1);
	localparam logic [LEN_W-1:0] MAX_FRAME_RESET = LEN_W'(65536);

	// Frame kinds
	localparam logic [1:0] KIND_BOUNDARY = 2'd0;
	localparam logic [1:0] KIND_CUT      = 2'd1;
	localparam logic [1:0] KIND_EOS      = 2'd2;
	localparam logic [1:0] KIND_NO_SLICE = 2'd3;

	// NAL unit types
	localparam logic [4:0] NAL_SLICE     = 5'd1;
	localparam logic [4:0] NAL_IDR       = 5'd5;
	localparam logic [4:0] NAL_SEI       = 5'd6;
	localparam logic [4:0] NAL_SPS       = 5'd7;
	localparam logic [4:0] NAL_PPS       = 5'd8;
	localparam logic [4:0] NAL_SUBSET    = 5'd15;
	localparam logic [4:0] NAL_EXT_SLICE = 5'd20;

	typedef logic [WIN_LEN-1:0][7:0] win_t;

	typedef struct packed {
		logic slice_start;
		logic frame_end;
	} nal_flags_t;

endpackage

// File: rtl/aus_in_if.sv
// Byte stream channel: one stream byte per word
interface aus_in_if import aus_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/aus_out_if.sv
// Frame channel: one frame description per word
interface aus_out_if import aus_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OFS_W-1:0] frame_offset;
	logic [LEN_W-1:0] frame_length;
	logic [1:0]       frame_kind;

	modport source (output valid, output frame_offset, output frame_length,
		output frame_kind, input ready);
	modport sink   (input valid, input frame_offset, input frame_length,
		input frame_kind, output ready);
endinterface

// File: rtl/aus_detect.sv
// Start code classifier over the nine byte look-ahead window
module aus_detect import aus_pkg::*; (
	input  win_t       win,
	output nal_flags_t flags
);

	logic       prefix;
	logic [4:0] nal_type;
	logic       slice_hit;
	logic       ext_hit;
	logic       non_slice;

	// Match the 00 00 01 prefix and pick the NAL type
	assign prefix   = (win[0] == 8'h00) && (win[1] == 8'h00) && (win[2] == 8'h01);
	assign nal_type = win[3][4:0];

	// Slice starts: first_mb bit is the top bit of the following byte, or of the fourth byte after the type for type 20
	assign slice_hit = ((nal_type == NAL_SLICE) || (nal_type == NAL_IDR)) && win[4][7];
	assign ext_hit   = (nal_type == NAL_EXT_SLICE) && win[7][7];
	assign non_slice = (nal_type == NAL_SUBSET) || (nal_type == NAL_SPS) ||
		(nal_type == NAL_PPS) || (nal_type == NAL_SEI);

	assign flags.slice_start = prefix && (slice_hit || ext_hit);
	assign flags.frame_end   = prefix && (slice_hit || ext_hit || non_slice);

endmodule

// File: rtl/h264_access_unit_splitter.sv
// A byte accepted lands in the input register, and its frame word (if any) is then
// loaded into the output register; a stall on the frame side holds the byte between them.
// Throughput: one byte per cycle, unless the output register is full and not read.
// Reset: arst_n clears the window, counters, offset and the valid bits of both registers;
// max_frame_bytes returns to 65536. End of stream also restarts offsets from zero.
module h264_access_unit_splitter import aus_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	aus_in_if.sink           stream,
	aus_out_if.source        frame
);

	`include "h264_access_unit_splitter_defines.svh"

	localparam logic [LEN_W-1:0]  LIMIT_MAX = LEN_W'(MAX_FRAME_LIMIT);
	localparam logic [LEN_W-1:0]  LIMIT_MIN = LEN_W'(MIN_FRAME_BYTES);
	localparam logic [LEN_W-1:0]  LOOK_LEN  = LEN_W'(LOOKAHEAD_BYTES);
	localparam logic [LEN_W-1:0]  WIN_LEN_L = LEN_W'(WIN_LEN);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN);

	// Configuration
	logic [LEN_W-1:0] max_frame_q;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Frame state
	win_t              win_q;
	logic [FILL_W-1:0] fill_q;
	logic [OFS_W-1:0]  ofs_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              seen_q;
	logic [LEN_W-1:0]  esf_q;

	// Output register
	logic             out_valid_q;
	logic [OFS_W-1:0] out_ofs_q;
	logic [LEN_W-1:0] out_len_q;
	logic [1:0]       out_kind_q;

	// Step logic
	logic              advance;
	logic [LEN_W-1:0]  limit;
	win_t              win_n;
	logic [FILL_W-1:0] fill_n;
	logic              full;
	logic [LEN_W-1:0]  cnt_n;
	logic [LEN_W-1:0]  pos;
	nal_flags_t        flags;
	logic              first_slice;
	logic              seen_n;
	logic              boundary;
	logic              cut;

	logic              emit;
	logic [LEN_W-1:0]  emit_len;
	logic [1:0]        emit_kind;

	// Advance the input word when the output register has room
	assign advance      = valid_s1 && (!out_valid_q || frame.ready);
	assign stream.ready = !valid_s1 || advance;

	assign frame.valid        = out_valid_q;
	assign frame.frame_offset = out_ofs_q;
	assign frame.frame_length = out_len_q;
	assign frame.frame_kind   = out_kind_q;

	// Clamp the length limit
	always_comb begin
		if (max_frame_q < LIMIT_MIN) begin
			limit = LIMIT_MIN;
		end else if (max_frame_q > LIMIT_MAX) begin
			limit = LIMIT_MAX;
		end else begin
			limit = max_frame_q;
		end
	end

	// Shift the new byte into the window and count it
	assign win_n  = {byte_s1, win_q[WIN_LEN-1:1]};
	assign fill_n = (fill_q == FILL_FULL) ? fill_q : fill_q + 1'b1;
	assign full   = (fill_n == FILL_FULL);
	assign cnt_n  = cnt_q + 1'b1;
	assign pos    = cnt_n - WIN_LEN_L;

	aus_detect u_detect (
		.win   (win_n),
		.flags (flags)
	);

	// Decide the candidate position
	assign first_slice = full && !seen_q && flags.slice_start;
	assign seen_n      = seen_q || first_slice;
	assign boundary    = full && seen_q && !last_s1 && (pos >= esf_q) && flags.frame_end;
	assign cut         = !boundary && !last_s1 && (cnt_n >= limit);
	assign emit        = boundary || last_s1 || cut;

	always_comb begin
		if (boundary) begin
			emit_len  = pos;
			emit_kind = KIND_BOUNDARY;
		end else if (last_s1) begin
			emit_len  = cnt_n;
			emit_kind = seen_n ? KIND_EOS : KIND_NO_SLICE;
		end else begin
			emit_len  = cnt_n;
			emit_kind = seen_n ? KIND_CUT : KIND_NO_SLICE;
		end
	end

	// Hold the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= MAX_FRAME_RESET;
		end else if (cfg_we) begin
			max_frame_q <= cfg_wdata;
		end
	end

	// Load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.data_byte;
			last_s1 <= stream.last_byte;
		end
	end

	// Update the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			fill_q <= '0;
			ofs_q  <= '0;
			cnt_q  <= '0;
			seen_q <= 1'b0;
			esf_q  <= '0;
		end else if (advance) begin
			win_q <= win_n;
			if (boundary) begin
				fill_q <= fill_n;
				ofs_q  <= ofs_q + OFS_W'(pos);
				cnt_q  <= WIN_LEN_L;
				seen_q <= flags.slice_start;
				esf_q  <= LOOK_LEN;
			end else if (last_s1) begin
				fill_q <= '0;
				ofs_q  <= '0;
				cnt_q  <= '0;
				seen_q <= 1'b0;
				esf_q  <= '0;
			end else if (cut) begin
				fill_q <= '0;
				ofs_q  <= ofs_q + OFS_W'(cnt_n);
				cnt_q  <= '0;
				seen_q <= 1'b0;
				esf_q  <= '0;
			end else begin
				fill_q <= fill_n;
				cnt_q  <= cnt_n;
				seen_q <= seen_n;
				if (first_slice) begin
					esf_q <= pos + LOOK_LEN;
				end
			end
		end
	end

	// Load or drain the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_ofs_q  <= ofs_q;
			out_len_q  <= emit_len;
			out_kind_q <= emit_kind;
		end
	end

	`AUS_ASSERT_ALWAYS(a_fill_range, fill_q <= FILL_FULL, "window fill out of range")
	`AUS_ASSERT_ALWAYS(a_cnt_covers_fill, cnt_q >= LEN_W'(fill_q), "frame count below window fill")
	`AUS_ASSERT_ALWAYS(a_cnt_limit, cnt_q <= LIMIT_MAX, "frame count beyond hard limit")
	`AUS_ASSERT(a_boundary_len, (out_valid_q && out_kind_q == KIND_BOUNDARY) |-> out_len_q >= LOOK_LEN, "boundary frame shorter than look-ahead")
	`AUS_ASSERT(a_stall_holds, (valid_s1 && !advance) |=> valid_s1, "input word lost while stalled")

endmodule

// File: tb/sv/frame_cut_checker.sv
// Frame word checker: predicts where the byte stream is cut and compares every frame word
module frame_cut_checker import aus_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	aus_in_if                stream,
	aus_out_if               frame,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [OFS_W-1:0] ofs;
		logic [LEN_W-1:0] len;
		logic [1:0]       kind;
	} frame_word_t;

	// Shadow of the splitter state
	win_t             win;
	int unsigned      fill;
	logic [OFS_W-1:0] frame_ofs;
	logic [LEN_W-1:0] frame_cnt;
	logic             slice_seen;
	logic [LEN_W-1:0] search_from;
	logic [LEN_W-1:0] max_reg;
	frame_word_t      frames_due[$];
	int               errs;

	function automatic logic start_code_at_head();
		return win[0] == 8'h00 && win[1] == 8'h00 && win[2] == 8'h01;
	endfunction

	function automatic logic slice_at_head();
		logic [4:0] t;
		t = win[3][4:0];
		if (!start_code_at_head())
			return 1'b0;
		if ((t == NAL_SLICE || t == NAL_IDR) && win[4][7])
			return 1'b1;
		return t == NAL_EXT_SLICE && win[7][7];
	endfunction

	function automatic logic end_at_head();
		logic [4:0] t;
		t = win[3][4:0];
		if (!start_code_at_head())
			return 1'b0;
		if (t == NAL_SUBSET || t == NAL_SPS || t == NAL_PPS || t == NAL_SEI)
			return 1'b1;
		return slice_at_head();
	endfunction

	task automatic clear_window();
		win         = '0;
		fill        = 0;
		frame_cnt   = '0;
		slice_seen  = 1'b0;
		search_from = '0;
	endtask

	// Advance the shadow by one stream byte and queue the frame word it causes, if any
	task automatic cut_stream_byte(input logic [7:0] b, input logic fin);
		logic [LEN_W-1:0] lim;
		logic [LEN_W-1:0] pos;
		lim = max_reg;
		if (lim < LEN_W'(MIN_FRAME_BYTES))
			lim = LEN_W'(MIN_FRAME_BYTES);
		if (lim > LEN_W'(MAX_FRAME_LIMIT))
			lim = LEN_W'(MAX_FRAME_LIMIT);

		// Fill the window, then slide it
		if (fill < WIN_LEN) begin
			win[fill] = b;
			fill++;
		end else begin
			win = {b, win[WIN_LEN-1:1]};
		end
		frame_cnt++;

		// Decide the candidate at the head of a full window
		if (fill == WIN_LEN) begin
			pos = frame_cnt - LEN_W'(WIN_LEN);
			if (!slice_seen) begin
				if (slice_at_head()) begin
					slice_seen  = 1'b1;
					search_from = pos + LEN_W'(LOOKAHEAD_BYTES);
				end
			end else if (!fin && pos >= search_from && end_at_head()) begin
				frames_due.push_back('{frame_ofs, pos, KIND_BOUNDARY});
				// Held bytes begin the next frame
				frame_ofs   = frame_ofs + OFS_W'(pos);
				frame_cnt   = LEN_W'(WIN_LEN);
				slice_seen  = slice_at_head();
				search_from = LEN_W'(LOOKAHEAD_BYTES);
				return;
			end
		end

		// Flush at end of stream; offsets restart from zero
		if (fin) begin
			frames_due.push_back('{frame_ofs, frame_cnt,
				slice_seen ? KIND_EOS : KIND_NO_SLICE});
			clear_window();
			frame_ofs = '0;
			return;
		end

		// Cut at the length limit
		if (frame_cnt >= lim) begin
			frames_due.push_back('{frame_ofs, frame_cnt,
				slice_seen ? KIND_CUT : KIND_NO_SLICE});
			frame_ofs = frame_ofs + OFS_W'(frame_cnt);
			clear_window();
		end
	endtask

	// Track config writes and byte words, compare frame words in order
	always @(posedge clk or negedge arst_n) begin : watch
		frame_word_t got;
		frame_word_t want;
		if (!arst_n) begin
			clear_window();
			frame_ofs = '0;
			max_reg   = MAX_FRAME_RESET;
			frames_due.delete();
			errs = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_we)
				max_reg = cfg_wdata;
			if (stream.valid && stream.ready)
				cut_stream_byte(stream.data_byte, stream.last_byte);
			if (frame.valid && frame.ready) begin
				got = '{frame.frame_offset, frame.frame_length, frame.frame_kind};
				if (frames_due.size() == 0) begin
					errs++;
					if (errs <= REPORT_MAX)
						$display("frame word with none due: ofs %0d len %0d kind %0d",
							got.ofs, got.len, got.kind);
				end else begin
					want = frames_due.pop_front();
					if (got.ofs !== want.ofs || got.len !== want.len ||
						got.kind !== want.kind) begin
						errs++;
						if (errs <= REPORT_MAX)
							$display("frame word mismatch: expected ofs %0d len %0d kind %0d, got ofs %0d len %0d kind %0d",
								want.ofs, want.len, want.kind, got.ofs, got.len, got.kind);
					end
				end
			end
			fail_count <= errs;
			pending    <= frames_due.size();
		end
	end

endmodule

// File: tb/sv/h264_access_unit_splitter_tb.sv
// Testbench top: drives byte streams and config into the splitter and reports the verdict
module h264_access_unit_splitter_tb import aus_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;
	localparam int SEGMENTS    = 10;
	localparam int SEG_BYTES   = 140;

	// Type 1 slice, then a type 20 slice that ends the frame, then end of stream
	localparam logic [7:0] SLICE_THEN_EXT [18] = '{
		8'h00, 8'h00, 8'h01, 8'h41, 8'h80, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h01, 8'h14, 8'h00, 8'h00, 8'h00, 8'h80,
		8'h33, 8'h00};
	// IDR slice padded out to the smallest limit
	localparam logic [7:0] IDR_TO_LIMIT [16] = '{
		8'h00, 8'h00, 8'h01, 8'h65, 8'h88, 8'h00, 8'h00, 8'h00,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;
	int               tx_idle;
	int               rx_idle;
	int               fail_count;
	int               pending;

	aus_in_if  stream_ch ();
	aus_out_if frame_ch ();

	h264_access_unit_splitter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stream    (stream_ch),
		.frame     (frame_ch)
	);

	frame_cut_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.stream     (stream_ch),
		.frame      (frame_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the frame side at random
	initial begin : sink_pacing
		frame_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			frame_ch.ready <= arst_n && ($urandom_range(99) >= rx_idle);
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((stream_ch.valid && stream_ch.ready) || (frame_ch.valid && frame_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Offer one byte word, with random gaps, and hold it until taken
	task automatic put_word(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < tx_idle) begin
			stream_ch.valid <= 1'b0;
			@(posedge clk);
		end
		stream_ch.valid     <= 1'b1;
		stream_ch.data_byte <= b;
		stream_ch.last_byte <= fin;
		do @(posedge clk); while (!stream_ch.ready);
	endtask

	// Hold the stream until every frame word due has come, then let the block settle
	task automatic drain_frames();
		stream_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic retune_limit(input logic [LEN_W-1:0] v);
		drain_frames();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mostly well-formed NAL units with random content, plus noise, broken prefixes and stream ends
	task automatic send_mixed_stream(input int n_bytes);
		int         sent;
		int         pick;
		int         run;
		logic [4:0] nal;
		sent = 0;
		while (sent < n_bytes) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				case ($urandom_range(7))
					0: nal = NAL_SLICE;
					1: nal = NAL_IDR;
					2: nal = NAL_EXT_SLICE;
					3: nal = NAL_SEI;
					4: nal = NAL_SPS;
					5: nal = NAL_PPS;
					6: nal = NAL_SUBSET;
					default: nal = 5'($urandom);
				endcase
				put_word(8'h00, 1'b0);
				put_word(8'h00, 1'b0);
				put_word(8'h01, 1'b0);
				put_word({3'($urandom), nal}, 1'b0);
				// Bias bit7 high so that slice headers qualify most of the time
				repeat (4) put_word({$urandom_range(3) != 0, 7'($urandom)}, 1'b0);
				run = $urandom_range(20);
				repeat (run) put_word(8'($urandom), 1'b0);
				sent += 8 + run;
			end else if (pick < 85) begin
				run = $urandom_range(10, 1);
				repeat (run) put_word(($urandom_range(1) != 0) ? 8'h00 : 8'($urandom), 1'b0);
				sent += run;
			end else if (pick < 93) begin
				if ($urandom_range(1) != 0) begin
					put_word(8'h00, 1'b0);
					sent++;
				end
				put_word(8'h00, 1'b0);
				put_word(8'h00, 1'b0);
				put_word(8'h01, 1'b0);
				put_word(8'($urandom), 1'b0);
				sent += 4;
			end else begin
				put_word(8'($urandom), 1'b1);
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		logic [LEN_W-1:0] lim;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		stream_ch.valid     = 1'b0;
		stream_ch.data_byte = 8'h00;
		stream_ch.last_byte = 1'b0;
		tx_idle             = 38;
		rx_idle             = 55;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Boundary on an extension slice, then end of stream, at the reset limit
		for (int i = 0; i < 18; i++)
			put_word(SLICE_THEN_EXT[i], i == 17);
		// Limit below the floor acts as the floor: cut at length, then a lone byte
		retune_limit(LEN_W'(5));
		for (int i = 0; i < 16; i++)
			put_word(IDR_TO_LIMIT[i], 1'b0);
		put_word(8'hFF, 1'b1);

		// Random segments over several limits and pacing modes
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			tx_idle = (seg < 4) ? 38 : (seg < 7) ? 55 : 0;
			rx_idle = (seg < 4) ? 55 : (seg < 7) ? 38 : 0;
			case (seg)
				0: lim = '0;
				1: lim = '1;
				2: lim = LEN_W'($urandom_range(64, 17));
				3: lim = LEN_W'(MIN_FRAME_BYTES);
				4: lim = LEN_W'(MAX_FRAME_LIMIT);
				5: lim = LEN_W'($urandom_range(400, 65));
				6: lim = LEN_W'(MIN_FRAME_BYTES - 1);
				7: lim = MAX_FRAME_RESET;
				8: lim = LEN_W'($urandom);
				default: lim = LEN_W'($urandom_range(200, 16));
			endcase
			retune_limit(lim);
			send_mixed_stream(SEG_BYTES);
		end

		drain_frames();
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
